// ===== design/cppu_pkg.sv =====
// ----------------------------------------------------------------------------
// cppu_pkg
// Shared types, constants and the arctangent table for the polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cppu_pkg;

   localparam int MAX_L         = 512;
   localparam int SUM_AW        = $clog2(MAX_L);
   localparam int CORDIC_STEPS  = 26;
   localparam int CHAIN_LEN     = 32;        // sqrt needs 32 steps, CORDIC 26
   localparam int XW            = 36;        // CORDIC x/y width
   localparam int ZW            = 34;        // angle width, 2^-30 rad units

   localparam logic signed [ZW-1:0] HALF_PI_30     = 34'sd1686629713;
   localparam logic [33:0]          TWO_PI_23      = 34'd52707179;
   localparam logic [33:0]          HALF_TWO_PI_23 = 34'd26353589;
   localparam logic [47:0]          SUM_MAX        = 48'hFFFF_FFFF_FFFF;

   localparam logic [7:0] REG_HALF_PHASE = 8'd0;
   localparam logic [7:0] REG_SUM_ENABLE = 8'd1;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [63:0]          nrem;
      logic [63:0]          root;
   } cell_data_type;

   function automatic logic signed [ZW-1:0] cppu_atan(input logic [4:0] idx);
      logic signed [ZW-1:0] a;
      case (idx)
         5'd0:  a = 34'sh3243F6A8;
         5'd1:  a = 34'sh1DAC6705;
         5'd2:  a = 34'sh0FADBAFC;
         5'd3:  a = 34'sh07F56EA6;
         5'd4:  a = 34'sh03FEAB76;
         5'd5:  a = 34'sh01FFD55B;
         5'd6:  a = 34'sh00FFFAAA;
         5'd7:  a = 34'sh007FFF55;
         5'd8:  a = 34'sh003FFFEA;
         5'd9:  a = 34'sh001FFFFD;
         5'd10: a = 34'sh000FFFFF;
         5'd11: a = 34'sh0007FFFF;
         5'd12: a = 34'sh0003FFFF;
         5'd13: a = 34'sh0001FFFF;
         5'd14: a = 34'sh0000FFFF;
         5'd15: a = 34'sh00007FFF;
         5'd16: a = 34'sh00003FFF;
         5'd17: a = 34'sh00001FFF;
         5'd18: a = 34'sh00000FFF;
         5'd19: a = 34'sh000007FF;
         5'd20: a = 34'sh000003FF;
         5'd21: a = 34'sh000001FF;
         5'd22: a = 34'sh000000FF;
         5'd23: a = 34'sh0000007F;
         5'd24: a = 34'sh0000003F;
         5'd25: a = 34'sh0000001F;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== design/cppu_cell.sv =====
// ----------------------------------------------------------------------------
// cppu_cell
// One step of CORDIC vectoring (for steps below CORDIC_STEPS) and one step of the bit-wise square root.
// ----------------------------------------------------------------------------
`default_nettype none

module cppu_cell
   import cppu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic [4:0]    step_idx,
   input  wire cell_data_type d_in,
   output cell_data_type      d_out
);

   cell_data_type        q_ff;
   cell_data_type        q_in;
   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   logic signed [ZW-1:0] ang;
   logic [63:0]          b;
   logic [63:0]          rb;

   always_comb begin
      q_in = d_in;
      dx   = d_in.x >>> step_idx;
      dy   = d_in.y >>> step_idx;
      ang  = cppu_atan(step_idx);
      if (32'(step_idx) < CORDIC_STEPS) begin
         if (d_in.y > 0) begin
            q_in.x = d_in.x + dy;
            q_in.y = d_in.y - dx;
            q_in.z = d_in.z + ang;
         end else begin
            q_in.x = d_in.x - dy;
            q_in.y = d_in.y + dx;
            q_in.z = d_in.z - ang;
         end
      end
      // trial bit for this step: 4^(31 - step)
      b  = 64'd1 << (6'd62 - {step_idx, 1'b0});
      rb = d_in.root + b;
      if (d_in.nrem >= rb) begin
         q_in.nrem = d_in.nrem - rb;
         q_in.root = (d_in.root >> 1) + b;
      end else begin
         q_in.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

`default_nettype wire

// ===== design/cppu_chain.sv =====
// ----------------------------------------------------------------------------
// cppu_chain
// Row of step cells; data advances one cell per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module cppu_chain
   import cppu_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_data_type head,
   output cell_data_type      tail
);

   cell_data_type link [0:CHAIN_LEN];

   assign link[0] = head;

   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
      cppu_cell u_cell (
         .clock    (clock),
         .step_idx (5'(g)),
         .d_in     (link[g]),
         .d_out    (link[g+1])
      );
   end

   assign tail = link[CHAIN_LEN];

endmodule

`default_nettype wire

// ===== design/cppu_sum_store.sv =====
// ----------------------------------------------------------------------------
// cppu_sum_store
// Per-L unitarity sum memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cppu_sum_store
   import cppu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [SUM_AW-1:0] rd_addr,
   output logic [47:0]            rd_data,
   input  wire logic              wr_en,
   input  wire logic [SUM_AW-1:0] wr_addr,
   input  wire logic [47:0]       wr_data
);

   logic [47:0] mem [0:MAX_L-1];
   logic [47:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ===== design/complex_polar_phase_unwrap.sv =====
// ----------------------------------------------------------------------------
// complex_polar_phase_unwrap
// Complex value to magnitude and unwrapped phase, with per-L |S|^2 sums.
// ----------------------------------------------------------------------------
// One item is in flight at a time. From transfer in, an item passes through
// normalising shifts (set by the size of the larger part), the cell chain
// (square root in every cell, CORDIC vectoring in the first CORDIC_STEPS
// cells, one step per cell), a set-up state, a restoring remainder for the
// 2*pi unwrap and a finishing state, which waits while the result register
// is full and not taken. An item with both parts zero goes straight to the
// finishing stage. A new item is taken the cycle after the previous one has
// left the finishing stage; the result register holds a result until the
// consumer takes it. After reset the sum memory is swept to zero, one entry
// a cycle over all MAX_L entries, during which no item is accepted; register
// writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_polar_phase_unwrap
   import cppu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,   // s_real, s_imag, l_index, zero pad
   input  wire logic         req_tuser,   // sweep_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata,   // magnitude, phase, unit_sum
   output logic              rsp_tuser,   // zero_mag
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic         csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_NORM, ST_CHAIN, ST_PREP, ST_DIV, ST_FIN
   } state_type;

   state_type            state_ff;
   logic                 clr_ff;
   logic [SUM_AW:0]      clr_cnt_ff;
   logic [5:0]           cnt_ff;
   logic                 half_ff;
   logic                 sum_en_ff;
   logic signed [31:0]   prev_ff;
   logic                 sweep_ff;
   logic                 zero_ff;
   logic [8:0]           l_ff;
   logic [63:0]          sq_re_ff;
   logic [63:0]          sq_im_ff;
   logic signed [XW-1:0] x_ff;
   logic signed [XW-1:0] y_ff;
   logic [32:0]          m_ff;
   cell_data_type        head_ff;
   logic [33:0]          rem_ff;
   logic [40:0]          div_ff;
   logic                 dneg_ff;
   logic [31:0]          mag_ff;
   logic                 out_v_ff;
   logic [111:0]         out_d_ff;
   logic                 out_u_ff;

   cell_data_type        tail;
   logic [47:0]          rd_data;
   logic                 accept;
   logic                 out_free;
   logic signed [31:0]   s_real;
   logic signed [31:0]   s_imag;
   logic [32:0]          ax;
   logic [32:0]          ay;
   logic signed [ZW-1:0] th;
   logic signed [31:0]   prev_eff;
   logic signed [33:0]   d;
   logic [33:0]          ad;
   logic signed [35:0]   e;
   logic signed [35:0]   ph;
   logic signed [31:0]   ph_sat;
   logic signed [31:0]   rep;
   logic [64:0]          n_rnd;
   logic [48:0]          sum_new;
   logic [47:0]          sum_sat;
   logic                 l_ok;
   logic                 wr_en;
   logic [SUM_AW-1:0]    wr_addr;
   logic [47:0]          wr_data;
   logic [47:0]          unit_sum;

   assign s_real     = $signed(req_tdata[31:0]);
   assign s_imag     = $signed(req_tdata[63:32]);
   assign req_tready = (state_ff == ST_IDLE) && !clr_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_v_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign ax = s_real[31] ? (33'd0 - 33'(s_real)) : 33'(s_real);
   assign ay = s_imag[31] ? (33'd0 - 33'(s_imag)) : 33'(s_imag);

   cppu_chain u_chain (
      .clock (clock),
      .head  (head_ff),
      .tail  (tail)
   );

   // finishing arithmetic
   always_comb begin
      th       = (tail.z + 34'sd64) >>> 7;
      prev_eff = sweep_ff ? 32'sd0 : prev_ff;
      d        = th - 34'(prev_eff);
      ad       = d[33] ? (34'd0 - d) : d;
      // d - k*2pi equals +-(remainder - pi)
      e        = $signed({2'b00, rem_ff}) - $signed({2'b00, HALF_TWO_PI_23});
      ph       = dneg_ff ? (36'(prev_eff) - e) : (36'(prev_eff) + e);
      if (ph > 36'sd2147483647) begin
         ph_sat = 32'sh7FFF_FFFF;
      end else if (ph < -36'sd2147483648) begin
         ph_sat = 32'sh8000_0000;
      end else begin
         ph_sat = ph[31:0];
      end
      rep      = half_ff ? (ph_sat >>> 1) : ph_sat;
      n_rnd    = {1'b0, sq_re_ff} + {1'b0, sq_im_ff} + 65'(1 << 27);
      sum_new  = {1'b0, rd_data} + 49'(n_rnd[64:28]);
      sum_sat  = sum_new[48] ? SUM_MAX : sum_new[47:0];
      l_ok     = 32'(l_ff) < MAX_L;
      if (!l_ok) begin
         unit_sum = '0;
      end else if (!zero_ff && sum_en_ff) begin
         unit_sum = sum_sat;
      end else begin
         unit_sum = rd_data;
      end
   end

   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff[SUM_AW-1:0];
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_FIN) && out_free && !zero_ff && sum_en_ff && l_ok;
         wr_addr = SUM_AW'(l_ff);
         wr_data = sum_sat;
      end
   end

   cppu_sum_store u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (SUM_AW'(req_tdata[72:64])),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         cnt_ff     <= '0;
         half_ff    <= 1'b0;
         sum_en_ff  <= 1'b0;
         prev_ff    <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (SUM_AW+1)'(MAX_L - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (csr_valid) begin
            if (csr_index == REG_HALF_PHASE) begin
               half_ff <= csr_data;
            end else if (csr_index == REG_SUM_ENABLE) begin
               sum_en_ff <= csr_data;
            end
         end
         if ((state_ff == ST_FIN) && out_free) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sweep_ff <= req_tuser;
                  l_ff     <= req_tdata[72:64];
                  zero_ff  <= (s_real == 32'sd0) && (s_imag == 32'sd0);
                  sq_re_ff <= 64'(s_real) * 64'(s_real);
                  sq_im_ff <= 64'(s_imag) * 64'(s_imag);
                  x_ff     <= XW'(s_real);
                  y_ff     <= XW'(s_imag);
                  m_ff     <= (ax > ay) ? ax : ay;
                  state_ff <= ((s_real == 32'sd0) && (s_imag == 32'sd0)) ? ST_FIN : ST_NORM;
               end
            end
            ST_NORM: begin
               if (m_ff[32]) begin
                  head_ff.nrem <= sq_re_ff + sq_im_ff;
                  head_ff.root <= '0;
                  if (x_ff < 0) begin
                     if (y_ff >= 0) begin
                        head_ff.x <= y_ff;
                        head_ff.y <= -x_ff;
                        head_ff.z <= HALF_PI_30;
                     end else begin
                        head_ff.x <= -y_ff;
                        head_ff.y <= x_ff;
                        head_ff.z <= -HALF_PI_30;
                     end
                  end else begin
                     head_ff.x <= x_ff;
                     head_ff.y <= y_ff;
                     head_ff.z <= '0;
                  end
                  cnt_ff   <= '0;
                  state_ff <= ST_CHAIN;
               end else if (m_ff[32:24] == '0) begin
                  x_ff <= x_ff <<< 8;
                  y_ff <= y_ff <<< 8;
                  m_ff <= m_ff << 8;
               end else begin
                  x_ff <= x_ff <<< 1;
                  y_ff <= y_ff <<< 1;
                  m_ff <= m_ff << 1;
               end
            end
            ST_CHAIN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(CHAIN_LEN - 1)) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               rem_ff  <= ad + HALF_TWO_PI_23;
               dneg_ff <= d[33];
               div_ff  <= {TWO_PI_23, 7'd0};
               cnt_ff  <= '0;
               if (tail.nrem > tail.root) begin
                  mag_ff <= (tail.root + 64'd1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                               : 32'(tail.root + 64'd1);
               end else begin
                  mag_ff <= (tail.root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tail.root[31:0];
               end
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if ({7'd0, rem_ff} >= div_ff) begin
                  rem_ff <= 34'({7'd0, rem_ff} - div_ff);
               end
               div_ff <= div_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd7) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  out_u_ff <= zero_ff;
                  if (zero_ff) begin
                     out_d_ff <= {unit_sum, 32'd0, 32'd0};
                     prev_ff  <= prev_eff;
                  end else begin
                     out_d_ff <= {unit_sum, rep, mag_ff};
                     prev_ff  <= ph_sat;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

endmodule

`default_nettype wire
